@@ design/crcdf_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the frame deframer.
`timescale 1ns / 1ps
package crcdf_pkg;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [2:0] CFG_HEAD_FIRST    = 3'd0;
  localparam logic [2:0] CFG_HEAD_SECOND   = 3'd1;
  localparam logic [2:0] CFG_VERSION_PLAIN = 3'd2;
  localparam logic [2:0] CFG_VERSION_SPLIT = 3'd3;
  localparam logic [2:0] CFG_MAX_LENGTH    = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] ERR_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  head_first;
    logic [7:0]  head_second;
    logic [7:0]  version_plain;
    logic [7:0]  version_split;
    logic [11:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  version;
    logic [11:0] length;
    logic [15:0] err_count;
  } res_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/crc16_checked_frame_deframer_top.sv @@
// Top level of the CRC-16 checked, length-prefixed frame deframer.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one stream byte per item.
// Output channel (out_valid/out_ready/out_*) gives a payload byte as it
// arrives, then one good or failed verdict at the end of each frame.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// header bytes, accepted versions and length limit; cfg_ready is always high.
// Throughput: one byte per cycle while the output register is free or
// out_ready is high. An accepted byte lands in the input register, is parsed
// once the output register can take its result, and that result, if any, is
// captured in the output register, which drives out_valid. Header, version,
// length and CRC high bytes give no item.
// When out_ready is low a waiting result holds and the byte in the input
// register holds behind it; in_ready falls while both registers hold work
// and the receiver stalls. Reset (rst_n low, synchronous) restores the
// default registers, empties both stages and puts the parser back to
// hunting for a header.
`timescale 1ns / 1ps
module crc16_checked_frame_deframer_top
  import crcdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 2048
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_version,
  output logic [11:0] out_length,
  output logic [15:0] out_error_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_t        cfg;
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r, out_vld_nxt;
  res_t        out_r;
  logic        adv;
  logic        res_valid;
  res_t        res;
  logic [15:0] err_count;

  assign cfg_ready = 1'b1;

  crcdf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || !out_vld_r || out_ready;

  crcdf_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .rx_byte   (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .err_count (err_count)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = res_valid;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
    if (adv && res_valid) out_r <= res;
  end

  assign out_valid       = out_vld_r;
  assign out_kind        = out_r.kind;
  assign out_byte        = out_r.data;
  assign out_version     = out_r.version;
  assign out_length      = out_r.length;
  assign out_error_count = out_r.err_count;

  a_verdict_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> (out_byte == 8'h00))
    else $error("verdict item carries a nonzero byte");

  a_bad_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_BAD) |-> (out_error_count != 16'h0000))
    else $error("failed verdict with zero error count");

  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (err_count >= $past(err_count)))
    else $error("error count decreased");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_BYTE || out_kind == KIND_GOOD || out_kind == KIND_BAD))
    else $error("illegal item kind");

endmodule

@@ design/crcdf_cfg_regs.sv @@
// Configuration register file for the frame deframer.
`timescale 1ns / 1ps
module crcdf_cfg_regs
  import crcdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [11:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_first    <= 8'hA5;
      cfg_r.head_second   <= 8'h5A;
      cfg_r.version_plain <= 8'h01;
      cfg_r.version_split <= 8'h02;
      cfg_r.max_length    <= 12'd1404;
    end else if (wr_en) begin
      case (wr_index)
        CFG_HEAD_FIRST:    cfg_r.head_first    <= wr_data[7:0];
        CFG_HEAD_SECOND:   cfg_r.head_second   <= wr_data[7:0];
        CFG_VERSION_PLAIN: cfg_r.version_plain <= wr_data[7:0];
        CFG_VERSION_SPLIT: cfg_r.version_split <= wr_data[7:0];
        CFG_MAX_LENGTH:    cfg_r.max_length    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/crcdf_parser.sv @@
// Frame parser state, running CRC and result formation for one byte per step.
`timescale 1ns / 1ps
module crcdf_parser
  import crcdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 2048
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  cfg_t        cfg,
  output logic        res_valid,
  output res_t        res,
  output logic [15:0] err_count
);

  localparam int PW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  localparam logic [2:0] ST_HEAD1   = 3'd0;
  localparam logic [2:0] ST_HEAD2   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_LEN_HI  = 3'd3;
  localparam logic [2:0] ST_LEN_LO  = 3'd4;
  localparam logic [2:0] ST_PAYLOAD = 3'd5;
  localparam logic [2:0] ST_CRC_HI  = 3'd6;
  localparam logic [2:0] ST_CRC_LO  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [7:0]    ver_r, ver_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_hi_r, crc_hi_nxt;
  logic [15:0]   err_r, err_nxt;

  logic [15:0]   len_new;
  logic [PW-1:0] pos_inc;
  logic [15:0]   rx_crc;
  logic [15:0]   crc_upd;

  assign len_new = {len_r[15:8], rx_byte};
  assign pos_inc = pos_r + PW'(1);
  assign rx_crc  = {crc_hi_r, rx_byte};
  assign crc_upd = crc16_step(crc_r, rx_byte);

  always_comb begin
    state_nxt     = state_r;
    ver_nxt       = ver_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    crc_hi_nxt    = crc_hi_r;
    err_nxt       = err_r;
    res_valid     = 1'b0;
    res.kind      = KIND_BYTE;
    res.data      = 8'h00;
    res.version   = ver_r;
    res.length    = len_r[11:0];
    res.err_count = err_r;
    case (state_r)
      ST_HEAD1: begin
        if (rx_byte == cfg.head_first) state_nxt = ST_HEAD2;
      end
      ST_HEAD2: begin
        if (rx_byte == cfg.head_second) begin
          state_nxt = ST_VERSION;
        end else if (rx_byte != cfg.head_first) begin
          state_nxt = ST_HEAD1;
        end
      end
      ST_VERSION: begin
        ver_nxt = rx_byte;
        crc_nxt = crc16_step(CRC_INIT, rx_byte);
        if (rx_byte != cfg.version_plain && rx_byte != cfg.version_split) begin
          state_nxt = ST_HEAD1;
        end else begin
          state_nxt = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        len_nxt   = {rx_byte, 8'h00};
        crc_nxt   = crc_upd;
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        len_nxt = len_new;
        crc_nxt = crc_upd;
        if (len_new == 16'h0000 || len_new > {4'h0, cfg.max_length} || len_new > MAX_LEN) begin
          state_nxt = ST_HEAD1;
        end else begin
          pos_nxt   = '0;
          state_nxt = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        crc_nxt   = crc_upd;
        pos_nxt   = pos_inc;
        if (16'(pos_inc) >= len_r) state_nxt = ST_CRC_HI;
        res_valid = 1'b1;
        res.data  = rx_byte;
      end
      ST_CRC_HI: begin
        crc_hi_nxt = rx_byte;
        state_nxt  = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        state_nxt = ST_HEAD1;
        res_valid = 1'b1;
        if (rx_crc == crc_r) begin
          res.kind = KIND_GOOD;
        end else begin
          if (err_r != ERR_MAX) err_nxt = err_r + 16'd1;
          res.kind = KIND_BAD;
        end
        res.err_count = err_nxt;
      end
      default: begin
        state_nxt = ST_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HEAD1;
      ver_r    <= 8'h00;
      len_r    <= 16'h0000;
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      crc_hi_r <= 8'h00;
      err_r    <= 16'h0000;
    end else if (step) begin
      state_r  <= state_nxt;
      ver_r    <= ver_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
      err_r    <= err_nxt;
    end
  end

  assign err_count = err_r;

endmodule
